[design/span_cov_pkg.sv]
// span_cov_pkg: shared types and constants for the span coverage buffer
// used by span_cov_ctrl, span_cov_dp and span_coverage_buffer; no dependencies
package span_cov_pkg;

  localparam int COL_W            = 10;
  localparam int LINK_W           = 7;
  localparam int DEF_SCREEN_COLS  = 320;
  localparam int DEF_POOL_ENTRIES = 64;

  localparam logic [LINK_W-1:0] NIL_LINK = 7'h7F;

  // request transaction
  typedef struct packed {
    logic             req_type;
    logic [COL_W-1:0] range_start;
    logic [COL_W-1:0] range_end;
    logic             solid;
  } span_req_t;

  // result transaction
  typedef struct packed {
    logic [COL_W-1:0] frag_start;
    logic [COL_W-1:0] frag_end;
    logic             no_fragment;
    logic             pool_overflow;
    logic             last;
  } span_rsp_t;

  // how the request range relates to the entry under the walk
  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_TRIM_R,
    KIND_SPLIT,
    KIND_STOP,
    KIND_COVER,
    KIND_TRIM_L
  } span_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic eval;
    logic split_fin;
    logic fix;
    logic finish;
  } span_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       req_clear;
    logic       req_range_ok;
    logic       walk_more;
    logic       hold;
    span_kind_t kind;
    logic       solid;
    logic       free_ok;
    logic       prev_ok;
    logic       out_free;
    logic       clr_last;
  } span_stat_t;

endpackage

[design/span_coverage_buffer.sv]
// span_coverage_buffer: clear is an accept step plus a sweep over every pool entry, no transaction.
// query: a load step, a step per entry walked, a step if the walk runs off the list or hits the
// step limit, a step per freed entry with a predecessor, a step for a split and a step to close,
// plus result stalls. results trail the walk by one slot so the last flag is known; one pool read
// port sets the walk rate; the next item is accepted once the final transaction is registered.
// after reset both lists are empty until the first clear; pool contents are undefined until written.
module span_coverage_buffer #(
  parameter int SCREEN_COLS  = span_cov_pkg::DEF_SCREEN_COLS,
  parameter int POOL_ENTRIES = span_cov_pkg::DEF_POOL_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  span_cov_pkg::span_req_t req_data,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output span_cov_pkg::span_rsp_t rsp_data
);

  span_cov_pkg::span_cmd_t  cmd;
  span_cov_pkg::span_stat_t stat;

  // sequencer
  span_cov_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pool and walk datapath
  span_cov_dp #(
    .SCREEN_COLS  (SCREEN_COLS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[design/span_cov_ctrl.sv]
// span_cov_ctrl: sequencer for clear sweeps and list walks
// depends on span_cov_pkg for command, status and kind types
module span_cov_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  span_cov_pkg::span_stat_t stat,
  output span_cov_pkg::span_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_WALK  = 6'b000100,
    S_SPLIT = 6'b001000,
    S_FIX   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.req_clear) begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end else begin
            cmd.load   = 1'b1;
            state_next = stat.req_range_ok ? S_WALK : S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (!stat.walk_more) begin
          state_next = S_DONE;
        end else if (!stat.hold) begin
          cmd.eval = 1'b1;
          unique case (stat.kind) inside
            span_cov_pkg::KIND_SKIP, span_cov_pkg::KIND_TRIM_R: begin
              state_next = S_WALK;
            end
            span_cov_pkg::KIND_SPLIT: begin
              state_next = (stat.solid && stat.free_ok) ? S_SPLIT : S_DONE;
            end
            span_cov_pkg::KIND_COVER: begin
              state_next = (stat.solid && stat.prev_ok) ? S_FIX : S_WALK;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SPLIT: begin
        cmd.split_fin = 1'b1;
        state_next    = S_DONE;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_WALK;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a walk step never runs while a result would be lost
  assert property (@(posedge clk) disable iff (rst) cmd.eval |-> !stat.hold)
    else $error("walk step issued while result path is blocked");

  // a split that takes an entry is always completed next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && stat.kind == span_cov_pkg::KIND_SPLIT && stat.solid && stat.free_ok)
    |=> cmd.split_fin)
    else $error("split allocation not completed");

  // a clear sweep ends back in idle
  assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_step && stat.clr_last) |=> !req_stall)
    else $error("clear sweep did not return to idle");

endmodule

[design/span_cov_dp.sv]
// span_cov_dp: entry pool memories, walk registers, free list and result slots
// depends on span_cov_pkg; driven by span_cov_ctrl commands
module span_cov_dp #(
  parameter int SCREEN_COLS  = span_cov_pkg::DEF_SCREEN_COLS,
  parameter int POOL_ENTRIES = span_cov_pkg::DEF_POOL_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  span_cov_pkg::span_req_t  req_data,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output span_cov_pkg::span_rsp_t  rsp_data,
  input  span_cov_pkg::span_cmd_t  cmd,
  output span_cov_pkg::span_stat_t stat
);

  localparam int COL_W  = span_cov_pkg::COL_W;
  localparam int LINK_W = span_cov_pkg::LINK_W;
  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int STEP_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [LINK_W-1:0] NIL       = span_cov_pkg::NIL_LINK;
  localparam logic [LINK_W-1:0] POOL_LIM  = LINK_W'(POOL_ENTRIES);
  localparam logic [COL_W-1:0]  FULL_END  = COL_W'(SCREEN_COLS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_ENTRIES - 1);
  localparam logic [STEP_W-1:0] STEP_LIM  = STEP_W'(POOL_ENTRIES);

  // entry pool
  logic [COL_W-1:0]  mem_start [POOL_ENTRIES];
  logic [COL_W-1:0]  mem_end   [POOL_ENTRIES];
  logic [LINK_W-1:0] mem_link  [POOL_ENTRIES];
  logic [COL_W-1:0]  q_start;
  logic [COL_W-1:0]  q_end;
  logic [LINK_W-1:0] q_link;
  logic [IDX_W-1:0]  rd_addr;

  logic              we_start, we_end, we_link;
  logic [IDX_W-1:0]  wa_start, wa_end, wa_link;
  logic [COL_W-1:0]  wd_start, wd_end;
  logic [LINK_W-1:0] wd_link;

  // walk and list registers
  logic [COL_W-1:0]  xs, xe;
  logic              solid;
  logic [LINK_W-1:0] cur, cur_next;
  logic [LINK_W-1:0] prev, prev_next;
  logic [STEP_W-1:0] steps;
  logic [LINK_W-1:0] open_head, open_head_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  sp_addr;
  logic [COL_W-1:0]  sp_end;
  logic [LINK_W-1:0] sp_link;

  // result slots
  span_cov_pkg::span_rsp_t pend, out, res, fin;
  logic                    pend_valid, out_valid, res_valid, out_free;

  span_cov_pkg::span_kind_t kind;
  logic                     free_ok, prev_ok;

  assign free_ok  = free_head < POOL_LIM;
  assign prev_ok  = prev < POOL_LIM;
  assign out_free = !out_valid || !rsp_stall;

  // classify the entry under the walk
  always_comb begin
    if (q_end <= xs) begin
      kind = span_cov_pkg::KIND_SKIP;
    end else if (q_start < xs) begin
      kind = (q_end <= xe) ? span_cov_pkg::KIND_TRIM_R : span_cov_pkg::KIND_SPLIT;
    end else if (q_start >= xe) begin
      kind = span_cov_pkg::KIND_STOP;
    end else if (q_end <= xe) begin
      kind = span_cov_pkg::KIND_COVER;
    end else begin
      kind = span_cov_pkg::KIND_TRIM_L;
    end
  end

  // status to controller
  always_comb begin
    stat              = '0;
    stat.req_clear    = req_data.req_type;
    stat.req_range_ok = req_data.range_start < req_data.range_end;
    stat.walk_more    = (cur < POOL_LIM) && (steps != STEP_LIM);
    stat.hold         = pend_valid && !out_free;
    stat.kind         = kind;
    stat.solid        = solid;
    stat.free_ok      = free_ok;
    stat.prev_ok      = prev_ok;
    stat.out_free     = out_free;
    stat.clr_last     = clr_idx == LAST_IDX;
  end

  // visible fragment of one walk step
  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    if (cmd.eval) begin
      case (kind)
        span_cov_pkg::KIND_TRIM_R: begin
          res_valid      = 1'b1;
          res.frag_start = xs;
          res.frag_end   = q_end;
        end
        span_cov_pkg::KIND_SPLIT: begin
          res_valid         = 1'b1;
          res.frag_start    = xs;
          res.frag_end      = xe;
          res.pool_overflow = solid && !free_ok;
        end
        span_cov_pkg::KIND_COVER: begin
          res_valid      = 1'b1;
          res.frag_start = q_start;
          res.frag_end   = q_end;
        end
        span_cov_pkg::KIND_TRIM_L: begin
          res_valid      = 1'b1;
          res.frag_start = q_start;
          res.frag_end   = xe;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // final transaction of a request
  always_comb begin
    fin = pend;
    if (!pend_valid) begin
      fin             = '0;
      fin.no_fragment = 1'b1;
    end
    fin.last = 1'b1;
  end

  // pointer updates
  always_comb begin
    cur_next       = cur;
    prev_next      = prev;
    open_head_next = open_head;
    free_head_next = free_head;
    if (cmd.load) begin
      cur_next  = open_head;
      prev_next = NIL;
    end else if (cmd.clr_start) begin
      open_head_next = '0;
      free_head_next = LINK_W'(1);
    end else if (cmd.eval) begin
      case (kind)
        span_cov_pkg::KIND_SKIP, span_cov_pkg::KIND_TRIM_R: begin
          prev_next = cur;
          cur_next  = q_link;
        end
        span_cov_pkg::KIND_COVER: begin
          cur_next = q_link;
          if (solid) begin
            if (!prev_ok) begin
              open_head_next = q_link;
            end
            free_head_next = cur;
          end else begin
            prev_next = cur;
          end
        end
        default: begin
          cur_next = cur;
        end
      endcase
    end else if (cmd.split_fin) begin
      free_head_next = q_link;
    end
  end

  // read address follows the entry the next cycle looks at
  always_comb begin
    if (cmd.load) begin
      rd_addr = open_head[IDX_W-1:0];
    end else if (cmd.eval && kind == span_cov_pkg::KIND_SPLIT) begin
      rd_addr = free_head[IDX_W-1:0];
    end else begin
      rd_addr = cur_next[IDX_W-1:0];
    end
  end

  // pool write ports
  always_comb begin
    we_start = 1'b0;
    we_end   = 1'b0;
    we_link  = 1'b0;
    wa_start = cur[IDX_W-1:0];
    wa_end   = cur[IDX_W-1:0];
    wa_link  = cur[IDX_W-1:0];
    wd_start = xe;
    wd_end   = xs;
    wd_link  = free_head;
    if (cmd.clr_step) begin
      we_link  = 1'b1;
      wa_link  = clr_idx;
      wd_link  = (clr_idx == '0 || clr_idx == LAST_IDX) ? NIL
                                                      : LINK_W'(clr_idx) + LINK_W'(1);
      we_start = clr_idx == '0;
      we_end   = clr_idx == '0;
      wa_start = '0;
      wa_end   = '0;
      wd_start = '0;
      wd_end   = FULL_END;
    end else if (cmd.eval && solid) begin
      case (kind)
        span_cov_pkg::KIND_TRIM_R: begin
          we_end = 1'b1;
        end
        span_cov_pkg::KIND_SPLIT: begin
          we_end   = free_ok;
          we_link  = free_ok;
          we_start = free_ok;
          wa_start = free_head[IDX_W-1:0];
        end
        span_cov_pkg::KIND_COVER: begin
          we_link = 1'b1;
        end
        span_cov_pkg::KIND_TRIM_L: begin
          we_start = 1'b1;
        end
        default: begin
          we_link = 1'b0;
        end
      endcase
    end else if (cmd.split_fin) begin
      we_end  = 1'b1;
      wa_end  = sp_addr;
      wd_end  = sp_end;
      we_link = 1'b1;
      wa_link = sp_addr;
      wd_link = sp_link;
    end else if (cmd.fix) begin
      we_link = 1'b1;
      wa_link = prev[IDX_W-1:0];
      wd_link = cur;
    end
  end

  // pool memories with registered read
  always_ff @(posedge clk) begin
    if (we_start) begin
      mem_start[wa_start] <= wd_start;
    end
    if (we_end) begin
      mem_end[wa_end] <= wd_end;
    end
    if (we_link) begin
      mem_link[wa_link] <= wd_link;
    end
    q_start <= mem_start[rd_addr];
    q_end   <= mem_end[rd_addr];
    q_link  <= mem_link[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= NIL;
      prev       <= NIL;
      steps      <= '0;
      open_head  <= NIL;
      free_head  <= NIL;
      clr_idx    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cur       <= cur_next;
      prev      <= prev_next;
      open_head <= open_head_next;
      free_head <= free_head_next;
      if (cmd.load) begin
        steps <= '0;
      end else if (cmd.eval) begin
        steps <= steps + STEP_W'(1);
      end
      if (cmd.clr_start) begin
        clr_idx <= '0;
      end else if (cmd.clr_step) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (res_valid) begin
        pend_valid <= 1'b1;
      end
      if (cmd.finish || (res_valid && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs    <= req_data.range_start;
      xe    <= req_data.range_end;
      solid <= req_data.solid;
    end
    if (cmd.eval && kind == span_cov_pkg::KIND_SPLIT) begin
      sp_addr <= free_head[IDX_W-1:0];
      sp_end  <= q_end;
      sp_link <= q_link;
    end
    if (res_valid) begin
      pend <= res;
    end
    if (cmd.finish) begin
      out <= fin;
    end else if (res_valid && pend_valid) begin
      out <= pend;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_data  = out;

  // an empty answer is always the only and final transaction with zero columns
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.no_fragment)
    |-> (rsp_data.last && rsp_data.frag_start == '0 && rsp_data.frag_end == '0))
    else $error("no-fragment result malformed");

  // the final transaction is only built when the output slot can take it
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> out_free)
    else $error("finish while output slot is occupied");

  // every reported fragment is a non-empty column range
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.frag_start < res.frag_end))
    else $error("empty fragment reported");

endmodule
